// ===== hdl/mrcs_pkg.sv =====
// Shared types and codes for the matrix row/column swap block.
package mrcs_pkg;

    // Request kinds carried on the input tuser field
    typedef enum logic [1:0] {
        REQ_WRITE    = 2'd0,
        REQ_READ     = 2'd1,
        REQ_SWAP_ROW = 2'd2,
        REQ_SWAP_COL = 2'd3
    } mrcs_req_t;

    // Register index taken from paddr[2]
    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } mrcs_reg_t;

    // Which half of the shared map memory is addressed
    typedef enum logic {
        MAP_ROW = 1'b0,
        MAP_COL = 1'b1
    } mrcs_map_sel_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_A,
        ST_MAP_B,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_STORE,
        ST_DONE
    } mrcs_state_t;

    // Width of the count registers
    localparam int COUNT_W = 5;

    // Element width
    localparam int ELEM_W = 32;

endpackage

// ===== hdl/mrcs_map.sv =====
// Shared row/column map memory with per-entry valid bits (unwritten entry reads as identity).
module mrcs_map #(
    parameter int MW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic          wr_en,
    input  logic [MW:0]   addr,
    input  logic [MW-1:0] wdata,
    output logic [MW-1:0] rdata
);

    localparam int DEPTH = 2 << MW;

    logic [MW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [MW-1:0]    rdata_reg;

    // Map storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read; an entry never written holds its own index
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= valid_reg[addr] ? mem[addr] : addr[MW-1:0];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mrcs_store.sv =====
// Element memory, one write or one registered read per cycle.
module mrcs_store #(
    parameter int MW = 4
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic                        wr_en,
    input  logic [2*MW-1:0]             addr,
    input  logic [mrcs_pkg::ELEM_W-1:0] wdata,
    output logic [mrcs_pkg::ELEM_W-1:0] rdata
);

    localparam int DEPTH = 1 << (2 * MW);

    logic [mrcs_pkg::ELEM_W-1:0] mem [DEPTH];
    logic [mrcs_pkg::ELEM_W-1:0] rdata_reg;

    // Storage with registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/matrix_row_column_swap_top.sv =====
// Top level of the matrix row/column swap block: request sequencer, config regs, result register.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------------------
//  s_*     | in  | s_tvalid / s_tready       | tdata: first_index, second_index, write_value
//          |     |                           | tuser: req_type
//  m_*     | out | m_tvalid / m_tready       | tdata: read_value   tuser: status
//  apb     | in  | psel, penable, pwrite     | paddr 0: row_count, 4: column_count
//
// One word at a time: ready only while the sequencer is idle.
// A read/write runs MAP_A, MAP_B, STORE, DONE; a swap MAP_A, MAP_B, SWAP_A, SWAP_B, DONE;
// a flagged request only DONE. The single map memory port serves both map lookups in turn.
// A finished result sits in the output register, so a new word is taken while it waits.
// If that register is still full, the sequencer holds in its final state until it drains.
// Reset is asynchronous; maps read as identity after reset, no clearing pass.
module matrix_row_column_swap_top #(
    parameter int MAX_DIM = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] first_index, [7:4] second_index, [39:8] write_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic [0:0]  m_tuser,   // [0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = ($clog2(MAX_DIM + 1) > mrcs_pkg::COUNT_W)
                        ? $clog2(MAX_DIM + 1) : mrcs_pkg::COUNT_W;

    mrcs_pkg::mrcs_state_t state_reg, state_next;

    logic [mrcs_pkg::COUNT_W-1:0] row_count_reg, column_count_reg;

    // latched request
    mrcs_pkg::mrcs_req_t          req_reg;
    logic [MW-1:0]                a_reg, b_reg;
    logic [mrcs_pkg::ELEM_W-1:0]  wv_reg;
    logic                         flag_reg;
    logic [MW-1:0]                tmp_reg;

    // result register
    logic                         m_tvalid_reg;
    logic [mrcs_pkg::ELEM_W-1:0]  read_value_reg;
    logic                         status_reg;

    // sequencer outputs
    logic                         map_rd_en, map_wr_en;
    logic [MW:0]                  map_addr;
    logic [MW-1:0]                map_wdata, map_rdata;
    logic                         st_rd_en, st_wr_en;
    logic [mrcs_pkg::ELEM_W-1:0]  st_rdata;
    logic                         tmp_load, out_load;
    mrcs_pkg::mrcs_map_sel_t      map_sel;

    // request decode at the input
    mrcs_pkg::mrcs_req_t          in_req;
    logic [CW-1:0]                in_a, in_b, rows_ext, cols_ext, rows_eff, cols_eff;
    logic                         in_flag, accept, cfg_wr;

    assign accept = s_tvalid && s_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= mrcs_pkg::COUNT_W'(16);
            column_count_reg <= mrcs_pkg::COUNT_W'(16);
        end
        else if (cfg_wr)
        begin
            case (mrcs_pkg::mrcs_reg_t'(paddr[2]))
                mrcs_pkg::REG_ROW_COUNT: row_count_reg    <= pwdata[mrcs_pkg::COUNT_W-1:0];
                mrcs_pkg::REG_COL_COUNT: column_count_reg <= pwdata[mrcs_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (mrcs_pkg::mrcs_reg_t'(paddr[2]))
            mrcs_pkg::REG_ROW_COUNT: prdata = 32'(row_count_reg);
            mrcs_pkg::REG_COL_COUNT: prdata = 32'(column_count_reg);
            default:                 prdata = '0;
        endcase
    end

    // Effective counts saturate at MAX_DIM; range check of the incoming word
    always_comb
    begin
        in_req   = mrcs_pkg::mrcs_req_t'(s_tuser);
        in_a     = CW'(s_tdata[3:0]);
        in_b     = CW'(s_tdata[7:4]);
        rows_ext = CW'(row_count_reg);
        cols_ext = CW'(column_count_reg);
        rows_eff = (rows_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : rows_ext;
        cols_eff = (cols_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : cols_ext;
        case (in_req)
            mrcs_pkg::REQ_WRITE,
            mrcs_pkg::REQ_READ:     in_flag = (in_a >= rows_eff) || (in_b >= cols_eff);
            mrcs_pkg::REQ_SWAP_ROW: in_flag = (in_a >= rows_eff) || (in_b >= rows_eff);
            mrcs_pkg::REQ_SWAP_COL: in_flag = (in_a >= cols_eff) || (in_b >= cols_eff);
            default:                in_flag = 1'b1;
        endcase
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= in_req;
            a_reg    <= MW'(s_tdata[3:0]);
            b_reg    <= MW'(s_tdata[7:4]);
            wv_reg   <= s_tdata[39:8];
            flag_reg <= in_flag;
        end
        if (tmp_load)
        begin
            tmp_reg <= map_rdata;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: two map lookups, then a store access or two map writes; a flagged request goes to DONE
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        map_rd_en  = 1'b0;
        map_wr_en  = 1'b0;
        map_sel    = (req_reg == mrcs_pkg::REQ_SWAP_COL) ? mrcs_pkg::MAP_COL
                                                         : mrcs_pkg::MAP_ROW;
        map_addr   = {map_sel, a_reg};
        map_wdata  = map_rdata;
        st_rd_en   = 1'b0;
        st_wr_en   = 1'b0;
        tmp_load   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            mrcs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = in_flag ? mrcs_pkg::ST_DONE : mrcs_pkg::ST_MAP_A;
                end
            end
            mrcs_pkg::ST_MAP_A:
            begin
                map_rd_en  = 1'b1;
                map_addr   = {map_sel, a_reg};
                state_next = mrcs_pkg::ST_MAP_B;
            end
            mrcs_pkg::ST_MAP_B:
            begin
                map_rd_en = 1'b1;
                tmp_load  = 1'b1;
                if (req_reg == mrcs_pkg::REQ_WRITE || req_reg == mrcs_pkg::REQ_READ)
                begin
                    map_addr   = {mrcs_pkg::MAP_COL, b_reg};
                    state_next = mrcs_pkg::ST_STORE;
                end
                else
                begin
                    map_addr   = {map_sel, b_reg};
                    state_next = mrcs_pkg::ST_SWAP_A;
                end
            end
            mrcs_pkg::ST_SWAP_A:
            begin
                map_wr_en  = 1'b1;
                map_addr   = {map_sel, a_reg};
                map_wdata  = map_rdata;
                state_next = mrcs_pkg::ST_SWAP_B;
            end
            mrcs_pkg::ST_SWAP_B:
            begin
                map_wr_en  = 1'b1;
                map_addr   = {map_sel, b_reg};
                map_wdata  = tmp_reg;
                state_next = mrcs_pkg::ST_DONE;
            end
            mrcs_pkg::ST_STORE:
            begin
                st_wr_en   = (req_reg == mrcs_pkg::REQ_WRITE);
                st_rd_en   = (req_reg == mrcs_pkg::REQ_READ);
                state_next = mrcs_pkg::ST_DONE;
            end
            mrcs_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mrcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Shared map memory (row half and column half)
    mrcs_map #(
        .MW (MW)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (map_rd_en),
        .wr_en (map_wr_en),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    // Element memory addressed by physical row and column
    mrcs_store #(
        .MW (MW)
    ) u_store (
        .clk   (clk),
        .rd_en (st_rd_en),
        .wr_en (st_wr_en),
        .addr  ({tmp_reg, map_rdata}),
        .wdata (wv_reg),
        .rdata (st_rdata)
    );

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result payload: read data only for a read that was done
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_value_reg <= (req_reg == mrcs_pkg::REQ_READ && !flag_reg) ? st_rdata : '0;
            status_reg     <= flag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = read_value_reg;
    assign m_tuser  = status_reg;

endmodule

// ===== hdl/mrcs_checker.sv =====
// Port-level checks for the matrix row/column swap block, bound to the top level.
module mrcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A flagged request returns zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("flagged result carries nonzero data");

    // The block is busy in the cycle after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // A new result is only loaded while the input side is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while sequencer idle");

endmodule

bind matrix_row_column_swap_top mrcs_checker u_mrcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
